// ===== hdl/pva_pkg.sv =====
`default_nettype none
package pva_pkg;

    localparam int NUM_VOICES_DEF   = 16;
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_RESULTS      = 16;

    // input commands
    localparam logic [3:0] CMD_NOTE_ON   = 4'd0;
    localparam logic [3:0] CMD_NOTE_OFF  = 4'd1;
    localparam logic [3:0] CMD_ALL_OFF   = 4'd2;
    localparam logic [3:0] CMD_SUSTAIN   = 4'd3;
    localparam logic [3:0] CMD_SOSTENUTO = 4'd4;
    localparam logic [3:0] CMD_SOFT      = 4'd5;
    localparam logic [3:0] CMD_CC        = 4'd6;
    localparam logic [3:0] CMD_TICK      = 4'd7;
    localparam logic [3:0] CMD_VOICE_DONE = 4'd8;
    localparam logic [3:0] CMD_STOP_ALL  = 4'd9;

    // result actions
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_START       = 3'd1;
    localparam logic [2:0] ACT_RELEASE     = 3'd2;
    localparam logic [2:0] ACT_FADE        = 3'd3;
    localparam logic [2:0] ACT_STOP        = 3'd4;
    localparam logic [2:0] ACT_ALL_STOPPED = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_GROUP_CHANNEL = 3'd0;
    localparam logic [2:0] CFG_LOWEST_NOTE   = 3'd1;
    localparam logic [2:0] CFG_HIGHEST_NOTE  = 3'd2;
    localparam logic [2:0] CFG_FADE_SAMPLES  = 3'd3;
    localparam logic [2:0] CFG_BLOCK_LENGTH  = 3'd4;

    // controller numbers that act as pedals
    localparam logic [6:0] CC_SUSTAIN   = 7'd64;
    localparam logic [6:0] CC_SOSTENUTO = 7'd66;
    localparam logic [6:0] CC_SOFT      = 7'd67;
    localparam logic [6:0] CC_DOWN_MIN  = 7'd64;

    typedef struct packed {
        logic [3:0]  voice;
        logic [2:0]  action;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [15:0] fade;
    } res_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [4:0]  chan;
        logic [6:0]  velocity;
        logic [31:0] age;
    } pend_t;

    typedef struct packed {
        logic push;
        logic fin;
    } ostage_ctl_t;

    typedef struct packed {
        logic can_push;
        logic fin_ok;
    } ostage_sts_t;

endpackage
`default_nettype wire

// ===== hdl/pva_if.sv =====
`default_nettype none
interface pva_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] command;
    logic [4:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       pedal_down;
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic [3:0] voice_index;
    modport source (output valid, command, channel, note, velocity, pedal_down,
                    cc_number, cc_value, voice_index, input ready);
    modport sink (input valid, command, channel, note, velocity, pedal_down,
                  cc_number, cc_value, voice_index, output ready);
endinterface

interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  voice;
    logic [2:0]  action;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [15:0] fade_position;
    logic        last;
    modport source (output valid, voice, action, out_note, out_velocity, fade_position,
                    last, input ready);
    modport sink (input valid, voice, action, out_note, out_velocity, fade_position,
                  last, output ready);
endinterface

interface pva_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pva_out_stage.sv =====
`default_nettype none
module pva_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pva_pkg::ostage_ctl_t ctl,
    input  pva_pkg::res_t        res,
    output pva_pkg::ostage_sts_t sts,
    pva_out_if.source            results
);
    import pva_pkg::*;

    logic hold_v_reg;
    logic out_v_reg;
    res_t hold_reg;
    res_t out_reg;
    logic last_reg;
    logic out_free;
    logic load;

    assign out_free     = !out_v_reg || results.ready;
    assign sts.can_push = !hold_v_reg || out_free;
    assign sts.fin_ok   = out_free;
    assign load         = (ctl.push && hold_v_reg) || ctl.fin;

    // track which of the two stages hold a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.push)
                hold_v_reg <= 1'b1;
            else if (ctl.fin)
                hold_v_reg <= 1'b0;
            if (load)
                out_v_reg <= 1'b1;
            else if (results.ready)
                out_v_reg <= 1'b0;
        end
    end

    // hold the newest result back until we know whether it is the final one
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            hold_reg <= res;
        if (ctl.push && hold_v_reg)
        begin
            out_reg  <= hold_reg;
            last_reg <= 1'b0;
        end
        else if (ctl.fin)
        begin
            out_reg  <= hold_v_reg ? hold_reg : '0;
            last_reg <= 1'b1;
        end
    end

    assign results.valid         = out_v_reg;
    assign results.voice         = out_reg.voice;
    assign results.action        = out_reg.action;
    assign results.out_note      = out_reg.note;
    assign results.out_velocity  = out_reg.velocity;
    assign results.fade_position = out_reg.fade;
    assign results.last          = last_reg;

endmodule
`default_nettype wire

// ===== hdl/poly_voice_allocator_with_pedals.sv =====
// Polyphonic voice allocator with sustain, sostenuto and soft pedals.
// Channels: events (valid/ready) carries one MIDI-style event per transaction;
// results (valid/ready) returns one or more per-voice commands for each event,
// the final one marked by last; cfg (valid/ready, always ready) writes the
// group channel, note range, steal fade length and block length.
// Each event is handled by a sequencer that visits one voice slot per cycle
// while the results side does not stall, through a single shared slot-update
// and age-compare unit. A walking event (note-on, note-off, all-off, pedal
// release, sostenuto down, tick) visits the slots in turn and then marks its
// final result in a flush state before the next event is taken; a note-on that
// finds a free slot stops there. A note-on that has to steal walks the slots up
// to three times (free, releasing, any) and then marks the victim in a steal
// state. Voice-done acts on the named slot and stop-all clears every slot at
// once; sustain-down, soft and ignored events go straight to the flush.
// events.ready is low while an event is in progress. A stalled results receiver
// stops the slot walk at the next slot that has a command to report; a stall
// loses nothing, but results past MAX_RESULTS per event are dropped. The last
// result waits in the output register while the next event is already accepted.
// Reset clears all slots to stopped, all pedals up and the age counter to zero,
// and loads the configuration defaults; no clearing pass is needed.
`default_nettype none
module poly_voice_allocator_with_pedals #(
    parameter int NUM_VOICES   = pva_pkg::NUM_VOICES_DEF,
    parameter int NUM_CHANNELS = pva_pkg::NUM_CHANNELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pva_in_if.sink    events,
    pva_out_if.source results,
    pva_cfg_if.sink   cfg
);
    import pva_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_STEAL = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [1:0] PASS_FREE = 2'd0;
    localparam logic [1:0] PASS_REL  = 2'd1;
    localparam logic [1:0] PASS_ANY  = 2'd2;

    localparam logic [3:0] OP_NOTE_ON  = 4'd0;
    localparam logic [3:0] OP_NOTE_OFF = 4'd1;
    localparam logic [3:0] OP_ALL_OFF  = 4'd2;
    localparam logic [3:0] OP_SUS_UP   = 4'd3;
    localparam logic [3:0] OP_SOS_DOWN = 4'd4;
    localparam logic [3:0] OP_SOS_UP   = 4'd5;
    localparam logic [3:0] OP_TICK     = 4'd6;
    localparam logic [3:0] OP_VDONE    = 4'd7;
    localparam logic [3:0] OP_STOP_ALL = 4'd8;

    localparam logic [1:0] M_STOP = 2'd0;
    localparam logic [1:0] M_PLAY = 2'd1;
    localparam logic [1:0] M_REL  = 2'd2;

    localparam logic [3:0] F_KEY   = 4'b0001;
    localparam logic [3:0] F_SUS   = 4'b0010;
    localparam logic [3:0] F_SOS   = 4'b0100;
    localparam logic [3:0] F_STEAL = 4'b1000;

    localparam logic [2:0] P_SUS  = 3'b001;
    localparam logic [2:0] P_SOS  = 3'b010;
    localparam logic [2:0] P_SOFT = 3'b100;

    // configuration
    logic [4:0]  grp_reg;
    logic [6:0]  lo_reg;
    logic [6:0]  hi_reg;
    logic [15:0] fsamp_reg;
    logic [12:0] blk_reg;

    // slot records
    logic [6:0]  slot_note_reg  [NUM_VOICES];
    logic [4:0]  slot_chan_reg  [NUM_VOICES];
    logic [1:0]  slot_mode_reg  [NUM_VOICES];
    logic [3:0]  slot_flags_reg [NUM_VOICES];
    logic [31:0] slot_age_reg   [NUM_VOICES];
    logic [15:0] slot_fade_reg  [NUM_VOICES];
    pend_t       slot_pend_reg  [NUM_VOICES];
    logic [2:0]  ped_reg        [NUM_CHANNELS + 1];
    logic [31:0] age_reg, age_next;

    // sequencer
    logic [1:0]    state_reg, state_next;
    logic [3:0]    op_reg, op_next;
    logic [1:0]    pass_reg, pass_next;
    logic [VW-1:0] idx_reg, idx_next;
    logic [VW-1:0] pick_reg, pick_next;
    logic          pickv_reg, pickv_next;
    logic [31:0]   best_reg, best_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [4:0]    it_ch_reg, it_ch_next;
    logic [6:0]    it_note_reg, it_note_next;
    logic [6:0]    it_vel_reg, it_vel_next;
    logic          it_sus_reg, it_sus_next;

    // slot access
    logic [VW-1:0] rd_idx;
    logic [6:0]    s_note;
    logic [4:0]    s_chan;
    logic [1:0]    s_mode;
    logic [3:0]    s_flags;
    logic [31:0]   s_age;
    logic [15:0]   s_fade;
    pend_t         s_pend;
    logic          s_steal;
    logic          last_i;

    logic        wr_en;
    logic [6:0]  wr_note;
    logic [4:0]  wr_chan;
    logic [1:0]  wr_mode;
    logic [3:0]  wr_flags;
    logic [31:0] wr_age;
    logic [15:0] wr_fade;
    logic        pend_wr;
    pend_t       wr_pend;
    logic        clear_all;
    logic        ped_wr;
    logic [CW-1:0] ped_idx;
    logic [2:0]  ped_val;

    logic        emit;
    res_t        em;
    logic        emit_eff;
    logic        stall;
    ostage_ctl_t octl;
    ostage_sts_t osts;

    logic        in_acc;
    logic        ch_ok;
    logic [2:0]  ped_cur;
    logic [14:0] vprod;
    logic [1:0]  pk;
    logic        pdown;
    logic [3:0]  f;
    logic        cand;
    logic        better;
    logic [16:0] pos;

    assign events.ready = (state_reg == S_IDLE);
    assign in_acc       = events.valid && events.ready;
    assign cfg.ready    = 1'b1;

    assign rd_idx  = (state_reg == S_STEAL) ? pick_reg : idx_reg;
    assign s_note  = slot_note_reg[rd_idx];
    assign s_chan  = slot_chan_reg[rd_idx];
    assign s_mode  = slot_mode_reg[rd_idx];
    assign s_flags = slot_flags_reg[rd_idx];
    assign s_age   = slot_age_reg[rd_idx];
    assign s_fade  = slot_fade_reg[rd_idx];
    assign s_pend  = slot_pend_reg[rd_idx];
    assign s_steal = |(s_flags & F_STEAL);
    assign last_i  = (idx_reg == VW'(NUM_VOICES - 1));

    assign ch_ok   = (events.channel <= 5'(NUM_CHANNELS));
    assign ped_cur = ped_reg[CW'(events.channel)];
    assign vprod   = 15'(events.velocity) * 15'd179;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg   <= 5'd0;
            lo_reg    <= 7'd0;
            hi_reg    <= 7'd127;
            fsamp_reg <= 16'd240;
            blk_reg   <= 13'd64;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GROUP_CHANNEL: grp_reg   <= cfg.data[4:0];
                CFG_LOWEST_NOTE:   lo_reg    <= cfg.data[6:0];
                CFG_HIGHEST_NOTE:  hi_reg    <= cfg.data[6:0];
                CFG_FADE_SAMPLES:  fsamp_reg <= cfg.data;
                CFG_BLOCK_LENGTH:  blk_reg   <= cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // sequencer and shared slot-update unit
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pass_next    = pass_reg;
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        pickv_next   = pickv_reg;
        best_next    = best_reg;
        cnt_next     = cnt_reg;
        age_next     = age_reg;
        it_ch_next   = it_ch_reg;
        it_note_next = it_note_reg;
        it_vel_next  = it_vel_reg;
        it_sus_next  = it_sus_reg;
        wr_en     = 1'b0;
        wr_note   = s_note;
        wr_chan   = s_chan;
        wr_mode   = s_mode;
        wr_flags  = s_flags;
        wr_age    = s_age;
        wr_fade   = s_fade;
        pend_wr   = 1'b0;
        wr_pend   = '0;
        clear_all = 1'b0;
        ped_wr    = 1'b0;
        ped_idx   = CW'(events.channel);
        ped_val   = ped_cur;
        emit      = 1'b0;
        em        = '0;
        octl      = '0;
        pk        = 2'd0;
        pdown     = events.pedal_down;
        f         = s_flags;
        cand      = 1'b0;
        better    = 1'b0;
        pos       = 17'(s_fade) + 17'(blk_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    it_ch_next   = events.channel;
                    it_note_next = events.note;
                    it_vel_next  = |(ped_cur & P_SOFT) ? vprod[14:8] : events.velocity;
                    it_sus_next  = |(ped_cur & P_SUS);
                    cnt_next     = 5'd0;
                    idx_next     = '0;
                    pickv_next   = 1'b0;
                    pass_next    = PASS_FREE;
                    state_next   = S_FLUSH;
                    // pedal kind: 1 sustain, 2 sostenuto, 3 soft
                    case (events.command)
                        CMD_SUSTAIN:   pk = 2'd1;
                        CMD_SOSTENUTO: pk = 2'd2;
                        CMD_SOFT:      pk = 2'd3;
                        CMD_CC:
                        begin
                            pdown = (events.cc_value >= CC_DOWN_MIN);
                            if (events.cc_number == CC_SUSTAIN)
                                pk = 2'd1;
                            else if (events.cc_number == CC_SOSTENUTO)
                                pk = 2'd2;
                            else if (events.cc_number == CC_SOFT)
                                pk = 2'd3;
                        end
                        default: ;
                    endcase
                    case (events.command)
                        CMD_NOTE_ON:
                        begin
                            if (ch_ok && (grp_reg == 5'd0 || grp_reg == events.channel)
                                && events.note >= lo_reg && events.note <= hi_reg)
                            begin
                                op_next    = OP_NOTE_ON;
                                state_next = S_WALK;
                            end
                        end
                        CMD_NOTE_OFF:
                        begin
                            if (ch_ok)
                            begin
                                op_next    = OP_NOTE_OFF;
                                state_next = S_WALK;
                            end
                        end
                        CMD_ALL_OFF:
                        begin
                            op_next    = OP_ALL_OFF;
                            state_next = S_WALK;
                        end
                        CMD_TICK:
                        begin
                            op_next    = OP_TICK;
                            state_next = S_WALK;
                        end
                        CMD_VOICE_DONE:
                        begin
                            if (32'(events.voice_index) < NUM_VOICES)
                            begin
                                op_next    = OP_VDONE;
                                idx_next   = VW'(events.voice_index);
                                state_next = S_WALK;
                            end
                        end
                        CMD_STOP_ALL:
                        begin
                            op_next    = OP_STOP_ALL;
                            state_next = S_WALK;
                        end
                        default: ;
                    endcase
                    // pedal changes
                    if (ch_ok && pk != 2'd0)
                    begin
                        ped_wr = 1'b1;
                        case (pk)
                            2'd1:
                            begin
                                ped_val = pdown ? (ped_cur | P_SUS) : (ped_cur & ~P_SUS);
                                if (!pdown)
                                begin
                                    op_next    = OP_SUS_UP;
                                    state_next = S_WALK;
                                end
                            end
                            2'd2:
                            begin
                                ped_val    = pdown ? (ped_cur | P_SOS) : (ped_cur & ~P_SOS);
                                op_next    = pdown ? OP_SOS_DOWN : OP_SOS_UP;
                                state_next = S_WALK;
                            end
                            default:
                                ped_val = pdown ? (ped_cur | P_SOFT) : (ped_cur & ~P_SOFT);
                        endcase
                    end
                end
            end

            S_WALK:
            begin
                em.voice = 4'(rd_idx);
                if (last_i)
                    state_next = S_FLUSH;
                else
                    idx_next = idx_reg + VW'(1);
                case (op_reg)
                    OP_NOTE_ON:
                    begin
                        if (pass_reg == PASS_FREE)
                        begin
                            if (!s_steal && s_mode == M_STOP)
                            begin
                                age_next   = age_reg + 32'd1;
                                wr_en      = 1'b1;
                                wr_note    = it_note_reg;
                                wr_chan    = it_ch_reg;
                                wr_age     = age_reg + 32'd1;
                                wr_flags   = F_KEY;
                                wr_mode    = M_PLAY;
                                emit       = 1'b1;
                                em.action  = ACT_START;
                                em.note    = it_note_reg;
                                em.velocity = it_vel_reg;
                                state_next = S_FLUSH;
                            end
                            else if (last_i)
                            begin
                                pass_next  = PASS_REL;
                                idx_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        else
                        begin
                            cand   = !s_steal && (pass_reg == PASS_ANY || s_mode == M_REL);
                            better = cand && (!pickv_reg || s_age < best_reg);
                            if (better)
                            begin
                                pick_next  = idx_reg;
                                best_next  = s_age;
                                pickv_next = 1'b1;
                            end
                            if (last_i)
                            begin
                                if (pickv_reg || better)
                                    state_next = S_STEAL;
                                else if (pass_reg == PASS_REL)
                                begin
                                    pass_next  = PASS_ANY;
                                    idx_next   = '0;
                                    state_next = S_WALK;
                                end
                            end
                        end
                    end
                    OP_NOTE_OFF:
                    begin
                        if (!s_steal && s_note == it_note_reg && s_chan == it_ch_reg
                            && |(s_flags & F_KEY))
                        begin
                            f = (s_flags & ~F_KEY) | (it_sus_reg ? F_SUS : 4'b0000);
                            wr_en    = 1'b1;
                            wr_flags = f;
                            if (f == 4'b0000 && s_mode == M_PLAY)
                            begin
                                wr_mode   = M_REL;
                                emit      = 1'b1;
                                em.action = ACT_RELEASE;
                            end
                        end
                    end
                    OP_SUS_UP, OP_SOS_UP:
                    begin
                        f = (op_reg == OP_SUS_UP) ? F_SUS : F_SOS;
                        if (s_chan == it_ch_reg && |(s_flags & f))
                        begin
                            f = s_flags & ~f;
                            wr_en    = 1'b1;
                            wr_flags = f;
                            if (f == 4'b0000 && s_mode == M_PLAY)
                            begin
                                wr_mode   = M_REL;
                                emit      = 1'b1;
                                em.action = ACT_RELEASE;
                            end
                        end
                    end
                    OP_SOS_DOWN:
                    begin
                        if (s_chan == it_ch_reg && |(s_flags & F_KEY))
                        begin
                            wr_en    = 1'b1;
                            wr_flags = s_flags | F_SOS;
                        end
                    end
                    OP_ALL_OFF:
                    begin
                        if (!s_steal && s_mode == M_PLAY
                            && (it_ch_reg == 5'd0 || s_chan == it_ch_reg))
                        begin
                            wr_en     = 1'b1;
                            wr_flags  = 4'b0000;
                            wr_mode   = M_REL;
                            emit      = 1'b1;
                            em.action = ACT_RELEASE;
                        end
                    end
                    OP_TICK:
                    begin
                        if (s_steal)
                        begin
                            wr_en = 1'b1;
                            emit  = 1'b1;
                            if (pos >= 17'(fsamp_reg))
                            begin
                                wr_note     = s_pend.note;
                                wr_chan     = s_pend.chan;
                                wr_age      = s_pend.age;
                                wr_flags    = F_KEY;
                                wr_mode     = M_PLAY;
                                wr_fade     = 16'd0;
                                em.action   = ACT_START;
                                em.note     = s_pend.note;
                                em.velocity = s_pend.velocity;
                            end
                            else
                            begin
                                wr_fade   = pos[15:0];
                                em.action = ACT_FADE;
                                em.fade   = pos[15:0];
                            end
                        end
                    end
                    OP_VDONE:
                    begin
                        state_next = S_FLUSH;
                        idx_next   = idx_reg;
                        if (!s_steal && s_mode == M_REL)
                        begin
                            wr_en     = 1'b1;
                            wr_mode   = M_STOP;
                            emit      = 1'b1;
                            em.action = ACT_STOP;
                        end
                    end
                    default:
                    begin
                        // stop everything at once
                        state_next = S_FLUSH;
                        idx_next   = idx_reg;
                        clear_all  = 1'b1;
                        emit       = 1'b1;
                        em.voice   = 4'd0;
                        em.action  = ACT_ALL_STOPPED;
                    end
                endcase
            end

            S_STEAL:
            begin
                age_next   = age_reg + 32'd1;
                wr_en      = 1'b1;
                wr_flags   = s_flags | F_STEAL;
                wr_fade    = 16'd0;
                pend_wr    = 1'b1;
                wr_pend    = '{note: it_note_reg, chan: it_ch_reg, velocity: it_vel_reg,
                               age: age_reg + 32'd1};
                emit       = 1'b1;
                em.voice   = 4'(rd_idx);
                em.action  = ACT_FADE;
                state_next = S_FLUSH;
            end

            default:
            begin
                // mark the final result
                if (osts.fin_ok)
                begin
                    octl.fin   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase

        // drop results past the limit, stall when the output side is full
        emit_eff  = emit && (cnt_reg < 5'(MAX_RESULTS));
        stall     = emit_eff && !osts.can_push;
        octl.push = emit_eff && !stall;
        if (octl.push)
            cnt_next = cnt_reg + 5'd1;
        if (stall)
        begin
            state_next = state_reg;
            pass_next  = pass_reg;
            idx_next   = idx_reg;
            pick_next  = pick_reg;
            pickv_next = pickv_reg;
            best_next  = best_reg;
            age_next   = age_reg;
            wr_en      = 1'b0;
            pend_wr    = 1'b0;
            clear_all  = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NOTE_ON;
            pass_reg  <= PASS_FREE;
            idx_reg   <= '0;
            pick_reg  <= '0;
            pickv_reg <= 1'b0;
            cnt_reg   <= 5'd0;
            age_reg   <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            pass_reg  <= pass_next;
            idx_reg   <= idx_next;
            pick_reg  <= pick_next;
            pickv_reg <= pickv_next;
            cnt_reg   <= cnt_next;
            age_reg   <= age_next;
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        it_ch_reg   <= it_ch_next;
        it_note_reg <= it_note_next;
        it_vel_reg  <= it_vel_next;
        it_sus_reg  <= it_sus_next;
    end

    // pedal flags per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c <= NUM_CHANNELS; c++)
                ped_reg[c] <= 3'b000;
        end
        else if (ped_wr)
            ped_reg[ped_idx] <= ped_val;
    end

    // slot records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                slot_note_reg[v]  <= 7'd0;
                slot_chan_reg[v]  <= 5'd0;
                slot_mode_reg[v]  <= M_STOP;
                slot_flags_reg[v] <= 4'b0000;
                slot_age_reg[v]   <= 32'd0;
                slot_fade_reg[v]  <= 16'd0;
            end
        end
        else if (clear_all)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                slot_mode_reg[v]  <= M_STOP;
                slot_flags_reg[v] <= 4'b0000;
                slot_fade_reg[v]  <= 16'd0;
            end
        end
        else if (wr_en)
        begin
            slot_note_reg[rd_idx]  <= wr_note;
            slot_chan_reg[rd_idx]  <= wr_chan;
            slot_mode_reg[rd_idx]  <= wr_mode;
            slot_flags_reg[rd_idx] <= wr_flags;
            slot_age_reg[rd_idx]   <= wr_age;
            slot_fade_reg[rd_idx]  <= wr_fade;
        end
    end

    // note waiting on a steal
    always_ff @(posedge clk)
    begin
        if (pend_wr)
            slot_pend_reg[rd_idx] <= wr_pend;
    end

    pva_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (octl),
        .res     (em),
        .sts     (osts),
        .results (results)
    );

endmodule
`default_nettype wire

// ===== hdl/pva_checker.sv =====
`default_nettype none
module pva_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  out_voice,
    input logic [2:0]  out_action,
    input logic [6:0]  out_note,
    input logic [15:0] out_fade,
    input logic        out_last
);
    import pva_pkg::*;

    // an accepted event holds events.ready low in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("events ready right after an accepted transaction");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_voice) && $stable(out_action)
            && $stable(out_note) && $stable(out_fade) && $stable(out_last))
        else $error("stalled result changed");

    // all-stopped is a lone final result on voice 0
    a_all_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action == ACT_ALL_STOPPED |-> out_voice == 4'd0 && out_last)
        else $error("all-stopped result malformed");

    // only fade results carry a fade position
    a_fade_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_action != ACT_FADE |-> out_fade == 16'd0)
        else $error("fade position on a non-fade result");

endmodule

bind poly_voice_allocator_with_pedals pva_checker u_pva_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (events.valid),
    .in_ready   (events.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_voice  (results.voice),
    .out_action (results.action),
    .out_note   (results.out_note),
    .out_fade   (results.fade_position),
    .out_last   (results.last)
);
`default_nettype wire
